>>> hw/rtl/assert_macros.svh
// assertion macros used by the cipher top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property that must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_HOLDS(label, cond, msg)
`define ASSERT_IMPLIES(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> hw/rtl/tctr_pkg.sv
// shared types and constants of the tea counter-mode cipher
package tctr_pkg;

	// tea round constant
	localparam logic [31:0] TEA_DELTA = 32'h9E3779B9;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COUNTER_NONCE = 3'd4;

	// one block in flight through the round chain
	typedef struct packed {
		logic [31:0] w0;
		logic [31:0] w1;
		logic [63:0] data;
		logic        last;
	} item_t;

endpackage

>>> hw/rtl/tctr_cell.sv
// one half-round cell of the tea chain: updates one word and registers the block
module tctr_cell #(
	parameter logic [31:0] ROUND_SUM = 32'h9E3779B9,
	parameter bit          UPD_W1    = 1'b0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  tctr_pkg::item_t in_item,
	input  logic [31:0]     key_a,
	input  logic [31:0]     key_b,
	output logic            out_valid,
	output tctr_pkg::item_t out_item
);

	logic [31:0] src;
	logic [31:0] dst;
	logic [31:0] mix;
	logic [31:0] upd;
	tctr_pkg::item_t nxt;
	logic            valid_s1;
	tctr_pkg::item_t item_s1;

	// tea feistel function on the word not being updated
	always_comb begin
		src = UPD_W1 ? in_item.w0 : in_item.w1;
		dst = UPD_W1 ? in_item.w1 : in_item.w0;
		mix = ((src << 4) + key_a) ^ (src + ROUND_SUM) ^ ((src >> 5) + key_b);
		upd = dst + mix;
		nxt = in_item;
		if (UPD_W1) begin
			nxt.w1 = upd;
		end else begin
			nxt.w0 = upd;
		end
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	// payload register
	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

endmodule

>>> hw/rtl/tea_ctr_keystream_cipher.sv
// tea counter-mode cipher: config registers, half-round cell chain and output register
// an accepted request passes through every cell register of the chain and then the output register
// throughput: one block per cycle while the output is not stalled; each round is split over two cells of the chain
// a stalled output holds the whole chain and input tready falls until it is taken
// reset clears the key and nonce registers and every valid bit; payload is not reset
`include "assert_macros.svh"

module tea_ctr_keystream_cipher #(
	parameter int unsigned ROUND_COUNT = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [tctr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                   cfg_wdata,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [95:0]                   s_tdata,  // block_index [31:0], data_block [95:32]
	input  logic                          s_tlast,
	// output stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [63:0]                   m_tdata,  // result_block [63:0]
	output logic                          m_tlast
);

	localparam int unsigned NUM_CELLS = 2 * ROUND_COUNT;

	logic [31:0] key0_q;
	logic [31:0] key1_q;
	logic [31:0] key2_q;
	logic [31:0] key3_q;
	logic [63:0] nonce_q;

	logic            en;
	logic            chain_valid [0:NUM_CELLS];
	tctr_pkg::item_t chain_item  [0:NUM_CELLS];
	logic            chain_done;

	logic        out_valid_q;
	logic [63:0] out_data_q;
	logic        out_last_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q  <= '0;
			key1_q  <= '0;
			key2_q  <= '0;
			key3_q  <= '0;
			nonce_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tctr_pkg::REG_KEY_WORD_0:    key0_q  <= cfg_wdata[31:0];
				tctr_pkg::REG_KEY_WORD_1:    key1_q  <= cfg_wdata[31:0];
				tctr_pkg::REG_KEY_WORD_2:    key2_q  <= cfg_wdata[31:0];
				tctr_pkg::REG_KEY_WORD_3:    key3_q  <= cfg_wdata[31:0];
				tctr_pkg::REG_COUNTER_NONCE: nonce_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// whole chain moves unless a finished result is stuck at the output
	assign en       = m_tready || !out_valid_q;
	assign s_tready = en;

	// counter = zero-extended index xor nonce, enters the chain as the tea block
	assign chain_valid[0]     = s_tvalid;
	assign chain_item[0].w0   = s_tdata[31:0] ^ nonce_q[31:0];
	assign chain_item[0].w1   = nonce_q[63:32];
	assign chain_item[0].data = s_tdata[95:32];
	assign chain_item[0].last = s_tlast;

	// chain of half-round cells: even cells update word 0, odd cells word 1
	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		localparam logic [63:0] SUM_FULL = 64'(i / 2 + 1) * 64'(tctr_pkg::TEA_DELTA);
		localparam bit          IS_W1    = (i % 2) == 1;

		tctr_cell #(
			.ROUND_SUM (SUM_FULL[31:0]),
			.UPD_W1    (IS_W1)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (chain_valid[i]),
			.in_item   (chain_item[i]),
			.key_a     (IS_W1 ? key2_q : key0_q),
			.key_b     (IS_W1 ? key3_q : key1_q),
			.out_valid (chain_valid[i+1]),
			.out_item  (chain_item[i+1])
		);
	end

	assign chain_done = chain_valid[NUM_CELLS];

	// output register: keystream xor data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= chain_done;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= chain_item[NUM_CELLS].data ^
				{chain_item[NUM_CELLS].w1, chain_item[NUM_CELLS].w0};
			out_last_q <= chain_item[NUM_CELLS].last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	// checks on chain control
	`ASSERT_IMPLIES(a_stall_only_on_full_out, !s_tready, m_tvalid && !m_tready, "input stalled")
	`ASSERT_NEXT(a_accept_enters_chain, s_tvalid && s_tready, chain_valid[1], "request lost")
	`ASSERT_IMPLIES(a_out_from_chain, $rose(m_tvalid), $past(chain_done), "stray result")
	`ASSERT_NEXT(a_drain_clears_out, m_tvalid && m_tready && !chain_done, !m_tvalid, "result repeated")

endmodule
